@@ hw/rtl/ppd3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppd3_pkg: shared types and constants of the 3x3x3 product parity decoder
// Field widths, code geometry, status codes and small bit-count helpers.
// ============================================================================
package ppd3_pkg;

    // Code geometry
    localparam int DATA_W       = 27;
    localparam int CHECK_W      = 27;
    localparam int LAYERS       = 3;
    localparam int SIDE         = 3;
    localparam int CELLS        = 9;
    localparam int ROWCOL_BITS  = 18;
    localparam int LAYER_CHECKS = 6;
    localparam int STATUS_W     = 2;
    localparam int FLIPS_W      = 2;

    // Decode status codes
    localparam logic [STATUS_W-1:0] STATUS_CLEAN   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SINGLE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PAIR    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_UNFIXED = 2'd3;

    // Syndrome flags of one codeword
    typedef struct packed {
        logic [LAYERS-1:0][SIDE-1:0] row;
        logic [LAYERS-1:0][SIDE-1:0] col;
        logic [CELLS-1:0]            depth;
    } syndrome_t;

    // Count set bits of a three-bit flag group
    function automatic logic [1:0] count3(input logic [SIDE-1:0] v);
        return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
    endfunction

    // Count set bits of the depth flags
    function automatic logic [3:0] count9(input logic [CELLS-1:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < CELLS; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ppd3_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppd3 channel interfaces
// Valid/ready channels for received codewords and decoded results.
// ============================================================================
interface ppd3_code_if;
    logic                          valid;
    logic                          ready;
    logic [ppd3_pkg::DATA_W-1:0]   data_word;
    logic [ppd3_pkg::CHECK_W-1:0]  check_word;

    modport source (output valid, output data_word, output check_word, input ready);
    modport sink   (input valid, input data_word, input check_word, output ready);
endinterface

interface ppd3_result_if;
    logic                          valid;
    logic                          ready;
    logic [ppd3_pkg::DATA_W-1:0]   corrected_data;
    logic [ppd3_pkg::STATUS_W-1:0] decode_status;
    logic [ppd3_pkg::FLIPS_W-1:0]  bits_flipped;

    modport source (output valid, output corrected_data, output decode_status,
                    output bits_flipped, input ready);
    modport sink   (input valid, input corrected_data, input decode_status,
                    input bits_flipped, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ppd3_syndrome.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppd3_syndrome: syndrome generator
// XOR trees for the row, column and depth parity checks of one codeword.
// ============================================================================
module ppd3_syndrome (
    input  wire logic [ppd3_pkg::DATA_W-1:0]  data_word,
    input  wire logic [ppd3_pkg::CHECK_W-1:0] check_word,
    output ppd3_pkg::syndrome_t               syn
);
    import ppd3_pkg::*;

    // Recompute every parity group against its received check bit
    always_comb begin
        syn = '0;
        for (int lay = 0; lay < LAYERS; lay++) begin
            for (int a = 0; a < SIDE; a++) begin
                syn.row[lay][a] = data_word[lay*CELLS + SIDE*a]
                                ^ data_word[lay*CELLS + SIDE*a + 1]
                                ^ data_word[lay*CELLS + SIDE*a + 2]
                                ^ check_word[lay*LAYER_CHECKS + a];
                syn.col[lay][a] = data_word[lay*CELLS + a]
                                ^ data_word[lay*CELLS + a + SIDE]
                                ^ data_word[lay*CELLS + a + 2*SIDE]
                                ^ check_word[lay*LAYER_CHECKS + SIDE + a];
            end
        end
        for (int c = 0; c < CELLS; c++) begin
            syn.depth[c] = data_word[c] ^ data_word[c + CELLS] ^ data_word[c + 2*CELLS]
                         ^ check_word[ROWCOL_BITS + c];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ppd3_correct.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ppd3_correct: correction decision
// Single-error repair per layer, else one pair repair, and status coding.
// ============================================================================
module ppd3_correct (
    input  wire logic [ppd3_pkg::DATA_W-1:0]   data_word,
    input  wire ppd3_pkg::syndrome_t           syn,
    output logic [ppd3_pkg::DATA_W-1:0]        corrected_data,
    output logic [ppd3_pkg::STATUS_W-1:0]      decode_status,
    output logic [ppd3_pkg::FLIPS_W-1:0]       bits_flipped
);
    import ppd3_pkg::*;

    logic [DATA_W-1:0]  single_mask;
    logic [FLIPS_W-1:0] fixed_cnt;
    logic [DATA_W-1:0]  pair_mask;
    logic               pair_hit;
    logic               any_flag;

    // Flip the crossing bit in every layer with one row and one column flag
    always_comb begin
        single_mask = '0;
        fixed_cnt   = '0;
        for (int lay = 0; lay < LAYERS; lay++) begin
            if (count3(syn.row[lay]) == 2'd1 && count3(syn.col[lay]) == 2'd1) begin
                fixed_cnt = fixed_cnt + 2'd1;
                for (int a = 0; a < SIDE; a++) begin
                    for (int b = 0; b < SIDE; b++) begin
                        single_mask[lay*CELLS + SIDE*a + b] = syn.row[lay][a] & syn.col[lay][b];
                    end
                end
            end
        end
    end

    // Scan layers in order for the first pair candidate; a bad layer ends the scan
    always_comb begin
        logic       stop;
        logic [1:0] nr;
        logic [1:0] nc;
        stop      = 1'b0;
        pair_hit  = 1'b0;
        pair_mask = '0;
        for (int lay = 0; lay < LAYERS; lay++) begin
            nr = count3(syn.row[lay]);
            nc = count3(syn.col[lay]);
            if (!stop) begin
                if (nr == 2'd2 && nc != 2'd0) begin
                    stop = 1'b1;
                end else if ((nr == 2'd2 && nc == 2'd0) || (nr == 2'd0 && nc == 2'd2)) begin
                    stop = 1'b1;
                    if (count9(syn.depth) == 4'd2) begin
                        pair_hit                       = 1'b1;
                        pair_mask[lay*CELLS +: CELLS] = syn.depth;
                    end
                end
            end
        end
    end

    assign any_flag = (|syn.row) | (|syn.col) | (|syn.depth);

    // Pick the repair and code the status
    always_comb begin
        if (fixed_cnt != 2'd0) begin
            corrected_data = data_word ^ single_mask;
            decode_status  = STATUS_SINGLE;
            bits_flipped   = fixed_cnt;
        end else if (pair_hit) begin
            corrected_data = data_word ^ pair_mask;
            decode_status  = STATUS_PAIR;
            bits_flipped   = 2'd2;
        end else begin
            corrected_data = data_word;
            decode_status  = any_flag ? STATUS_UNFIXED : STATUS_CLEAN;
            bits_flipped   = 2'd0;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/product_parity_3d_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// product_parity_3d_decoder: 3x3x3 product parity code decoder
//
//   channel  direction  payload
//   code     in         data_word[26:0], check_word[26:0]
//   result   out        corrected_data[26:0], decode_status[1:0], bits_flipped[1:0]
//
// One codeword per cycle while the result register is not stalled; each request is
// captured in the input register on acceptance, then passes through the syndrome
// and correction logic into the result register.
// Reset clears both valid flags only.
// A stalled result holds; the input register accepts while it is empty or
// while the result register is free or being drained in the same cycle.
// ============================================================================
module product_parity_3d_decoder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    ppd3_code_if.sink       code,
    ppd3_result_if.source   result
);
    import ppd3_pkg::*;

    logic                s1_valid_reg;
    logic [DATA_W-1:0]   s1_data_reg;
    logic [CHECK_W-1:0]  s1_check_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FLIPS_W-1:0]  out_flips_reg;

    syndrome_t           syn;
    logic [DATA_W-1:0]   fix_data;
    logic [STATUS_W-1:0] fix_status;
    logic [FLIPS_W-1:0]  fix_flips;
    logic                out_free;
    logic                s1_free;

    // Advance when the next stage is empty or draining
    assign out_free   = !out_valid_reg || result.ready;
    assign s1_free    = !s1_valid_reg || out_free;
    assign code.ready = s1_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= code.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free && code.valid)
        begin
            s1_data_reg  <= code.data_word;
            s1_check_reg <= code.check_word;
        end
    end

    ppd3_syndrome u_syndrome (
        .data_word  (s1_data_reg),
        .check_word (s1_check_reg),
        .syn        (syn)
    );

    ppd3_correct u_correct (
        .data_word      (s1_data_reg),
        .syn            (syn),
        .corrected_data (fix_data),
        .decode_status  (fix_status),
        .bits_flipped   (fix_flips)
    );

    // Result register: hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_data_reg   <= fix_data;
            out_status_reg <= fix_status;
            out_flips_reg  <= fix_flips;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.corrected_data = out_data_reg;
    assign result.decode_status  = out_status_reg;
    assign result.bits_flipped   = out_flips_reg;

endmodule
`default_nettype wire

@@ test/ppd3_decode_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ppd3_decode_checker: result checker for the 3x3x3 product parity decoder
// Watches both channels, computes the expected correction of every accepted
// request and compares each delivered result against the oldest expectation.
// ============================================================================
module ppd3_decode_checker (
    input  logic        clk,
    input  logic        rst_n,
    ppd3_code_if        code,
    ppd3_result_if      result,
    output int unsigned fail_count,
    output int unsigned pending
);
    import ppd3_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]   corrected;
        logic [STATUS_W-1:0] status;
        logic [FLIPS_W-1:0]  flipped;
    } decode_result_t;

    decode_result_t expected_results [$];
    int unsigned    mismatch_total;

    assign fail_count = mismatch_total;

    // Recompute syndromes, then apply the single pass or the pair pass
    function automatic decode_result_t predict_decode(
        input logic [DATA_W-1:0]  data,
        input logic [CHECK_W-1:0] check
    );
        logic [SIDE-1:0]  rowf [LAYERS];
        logic [SIDE-1:0]  colf [LAYERS];
        logic [CELLS-1:0] depf;
        logic             any_flag;
        logic             done;
        int               fixed;
        int               hit_row;
        int               hit_col;
        int               nr;
        int               nc;
        decode_result_t   res;

        any_flag = 1'b0;
        for (int l = 0; l < LAYERS; l++) begin
            for (int i = 0; i < SIDE; i++) begin
                rowf[l][i] = data[l*CELLS + i*SIDE] ^ data[l*CELLS + i*SIDE + 1]
                           ^ data[l*CELLS + i*SIDE + 2] ^ check[l*LAYER_CHECKS + i];
                colf[l][i] = data[l*CELLS + i] ^ data[l*CELLS + i + SIDE]
                           ^ data[l*CELLS + i + 2*SIDE]
                           ^ check[l*LAYER_CHECKS + SIDE + i];
            end
            if (rowf[l] != '0 || colf[l] != '0)
                any_flag = 1'b1;
        end
        for (int i = 0; i < CELLS; i++) begin
            depf[i] = data[i] ^ data[i + CELLS] ^ data[i + 2*CELLS] ^ check[ROWCOL_BITS + i];
        end
        if (depf != '0)
            any_flag = 1'b1;

        res.corrected = data;
        res.status    = STATUS_CLEAN;
        res.flipped   = '0;
        fixed         = 0;

        // Flip the crossing of a lone row flag and a lone column flag
        for (int l = 0; l < LAYERS; l++) begin
            if ($countones(rowf[l]) == 1 && $countones(colf[l]) == 1) begin
                hit_row = 0;
                hit_col = 0;
                for (int i = 0; i < SIDE; i++) begin
                    if (rowf[l][i])
                        hit_row = i;
                    if (colf[l][i])
                        hit_col = i;
                end
                res.corrected[l*CELLS + hit_row*SIDE + hit_col] =
                    ~res.corrected[l*CELLS + hit_row*SIDE + hit_col];
                fixed++;
            end
        end

        if (fixed != 0) begin
            res.status  = STATUS_SINGLE;
            res.flipped = FLIPS_W'(fixed);
        end
        else begin
            // Search the first layer holding a pair on one row or one column
            done = 1'b0;
            for (int l = 0; l < LAYERS; l++) begin
                nr = $countones(rowf[l]);
                nc = $countones(colf[l]);
                if (!done) begin
                    if (nr == 2 && nc != 0) begin
                        done = 1'b1;
                    end
                    else if ((nr == 2 && nc == 0) || (nr == 0 && nc == 2)) begin
                        done = 1'b1;
                        if ($countones(depf) == 2) begin
                            res.corrected = res.corrected ^ (DATA_W'(depf) << (l*CELLS));
                            res.status    = STATUS_PAIR;
                            res.flipped   = FLIPS_W'(2);
                        end
                    end
                end
            end
            if (res.status == STATUS_CLEAN && any_flag)
                res.status = STATUS_UNFIXED;
        end
        return res;
    endfunction

    // Queue a prediction per accepted request, match each delivered result
    always @(posedge clk) begin
        decode_result_t exp_res;

        if (rst_n) begin
            if (code.valid && code.ready)
                expected_results.insert(expected_results.size(),
                                        predict_decode(code.data_word, code.check_word));
            if (result.valid && result.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: corrected_data %h, decode_status %0d",
                           result.corrected_data, result.decode_status);
                    mismatch_total++;
                end
                else begin
                    exp_res = expected_results.pop_front();
                    if (result.corrected_data !== exp_res.corrected) begin
                        $error("corrected_data: expected %h, actual %h",
                               exp_res.corrected, result.corrected_data);
                        mismatch_total++;
                    end
                    if (result.decode_status !== exp_res.status) begin
                        $error("decode_status: expected %0d, actual %0d",
                               exp_res.status, result.decode_status);
                        mismatch_total++;
                    end
                    if (result.bits_flipped !== exp_res.flipped) begin
                        $error("bits_flipped: expected %0d, actual %0d",
                               exp_res.flipped, result.bits_flipped);
                        mismatch_total++;
                    end
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb: regression bench of the 3x3x3 product parity decoder
// Sends directed error patterns, then random codewords with injected single,
// pair and stray errors, under bursty requests and a stalling receiver.
// ============================================================================
module tb;
    import ppd3_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned fail_count;
    int unsigned pending;
    int          burst_left = 0;

    // Receiver stall pattern state
    int          rx_mode = 0;
    int          rx_hold = 0;
    logic [15:0] rx_pattern = 16'hA5C3;
    logic [3:0]  rx_phase = '0;

    ppd3_code_if   code_ch ();
    ppd3_result_if result_ch ();

    product_parity_3d_decoder i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .code   (code_ch),
        .result (result_ch)
    );

    ppd3_decode_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .code       (code_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // Data bit of cell (layer, row, col)
    function automatic int cell_bit(input int l, input int r, input int c);
        return l*CELLS + r*SIDE + c;
    endfunction

    function automatic logic [DATA_W-1:0] bit_at(input int idx);
        return DATA_W'(1) << idx;
    endfunction

    // Encode: row and column parity per layer, then depth parity per cell
    function automatic logic [CHECK_W-1:0] compute_checks(input logic [DATA_W-1:0] d);
        logic [CHECK_W-1:0] c;

        c = '0;
        for (int l = 0; l < LAYERS; l++) begin
            for (int i = 0; i < SIDE; i++) begin
                c[l*LAYER_CHECKS + i] = d[cell_bit(l, i, 0)] ^ d[cell_bit(l, i, 1)]
                                      ^ d[cell_bit(l, i, 2)];
                c[l*LAYER_CHECKS + SIDE + i] = d[cell_bit(l, 0, i)] ^ d[cell_bit(l, 1, i)]
                                             ^ d[cell_bit(l, 2, i)];
            end
        end
        for (int i = 0; i < CELLS; i++) begin
            c[ROWCOL_BITS + i] = d[i] ^ d[i + CELLS] ^ d[i + 2*CELLS];
        end
        return c;
    endfunction

    // Present one request, idling for a random gap, possibly none, when a burst has run out
    task automatic send_codeword(input logic [DATA_W-1:0] d, input logic [CHECK_W-1:0] c);
        int gap;

        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160)
                                                    : $urandom_range(1, 16);
            if (gap != 0) begin
                code_ch.valid      <= 1'b0;
                code_ch.data_word  <= DATA_W'($urandom);
                code_ch.check_word <= CHECK_W'($urandom);
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        code_ch.valid      <= 1'b1;
        code_ch.data_word  <= d;
        code_ch.check_word <= c;
        do @(posedge clk); while (!code_ch.ready);
    endtask

    // Flip one of the 54 codeword bits
    task automatic flip_any(inout logic [DATA_W-1:0] d, inout logic [CHECK_W-1:0] c);
        int idx;

        idx = $urandom_range(0, DATA_W + CHECK_W - 1);
        if (idx < DATA_W)
            d ^= bit_at(idx);
        else
            c ^= CHECK_W'(1) << (idx - DATA_W);
    endtask

    // Two errors on one row or one column of a layer
    function automatic logic [DATA_W-1:0] pair_mask(input int l, input bit on_row);
        int line;
        int p;
        int q;

        line = $urandom_range(0, SIDE - 1);
        p    = $urandom_range(0, SIDE - 1);
        q    = (p + $urandom_range(1, SIDE - 1)) % SIDE;
        if (on_row)
            return bit_at(cell_bit(l, line, p)) | bit_at(cell_bit(l, line, q));
        return bit_at(cell_bit(l, p, line)) | bit_at(cell_bit(l, q, line));
    endfunction

    // Directed corner cases
    task automatic run_directed();
        logic [DATA_W-1:0] d;
        logic [CHECK_W-1:0] c;

        // Clean words at both extremes; the all-ones word is sent twice
        send_codeword('0, '0);
        d = '1;
        send_codeword(d, compute_checks(d));
        send_codeword('1, '1);

        // Single errors at the lowest and highest data bit
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(0), compute_checks(d));
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(DATA_W - 1), compute_checks(d));

        // Single errors in all three layers, then in two layers
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(0, 1, 2)) ^ bit_at(cell_bit(1, 2, 0))
                        ^ bit_at(cell_bit(2, 0, 1)), compute_checks(d));
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(0, 2, 2)) ^ bit_at(cell_bit(2, 1, 1)),
                      compute_checks(d));

        // Pair on one row, pair on one column
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(0, 1, 0)) ^ bit_at(cell_bit(0, 1, 2)),
                      compute_checks(d));
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(2, 0, 1)) ^ bit_at(cell_bit(2, 2, 1)),
                      compute_checks(d));

        // Pair with a third depth flag: no repair
        d = DATA_W'($urandom);
        c = compute_checks(d);
        c[ROWCOL_BITS + 4] = ~c[ROWCOL_BITS + 4];
        send_codeword(d ^ bit_at(cell_bit(1, 0, 0)) ^ bit_at(cell_bit(1, 0, 1)), c);

        // Diagonal pair in layer 0 blocks the pair in layer 1
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(0, 0, 0)) ^ bit_at(cell_bit(0, 1, 1))
                        ^ bit_at(cell_bit(1, 2, 0)) ^ bit_at(cell_bit(1, 2, 1)),
                      compute_checks(d));

        // Layer 0 with one row and two column flags is skipped; pair in layer 2
        d = DATA_W'($urandom);
        c = compute_checks(d);
        c[0]        = ~c[0];
        c[SIDE]     = ~c[SIDE];
        c[SIDE + 2] = ~c[SIDE + 2];
        send_codeword(d ^ bit_at(cell_bit(2, 0, 1)) ^ bit_at(cell_bit(2, 2, 1)), c);

        // Lone row, column and depth check errors
        d = DATA_W'($urandom);
        send_codeword(d, compute_checks(d) ^ CHECK_W'(1) << (LAYER_CHECKS + 2));
        d = DATA_W'($urandom);
        send_codeword(d, compute_checks(d) ^ CHECK_W'(1) << (2*LAYER_CHECKS + SIDE));
        d = DATA_W'($urandom);
        send_codeword(d, compute_checks(d) ^ CHECK_W'(1) << (ROWCOL_BITS + CELLS - 1));

        // Single in layer 0 wins over a pair in layer 1
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(0, 2, 0)) ^ bit_at(cell_bit(1, 1, 0))
                        ^ bit_at(cell_bit(1, 1, 2)), compute_checks(d));

        // Pair whose depth flags are cancelled by check errors
        d = DATA_W'($urandom);
        c = compute_checks(d);
        c[ROWCOL_BITS + 7] = ~c[ROWCOL_BITS + 7];
        c[ROWCOL_BITS + 8] = ~c[ROWCOL_BITS + 8];
        send_codeword(d ^ bit_at(cell_bit(0, 2, 1)) ^ bit_at(cell_bit(0, 2, 2)), c);

        // Whole row wrong
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(1, 0, 0)) ^ bit_at(cell_bit(1, 0, 1))
                        ^ bit_at(cell_bit(1, 0, 2)), compute_checks(d));

        // Same cell wrong in two layers
        d = DATA_W'($urandom);
        send_codeword(d ^ bit_at(cell_bit(0, 1, 1)) ^ bit_at(cell_bit(1, 1, 1)),
                      compute_checks(d));

        d = DATA_W'($urandom);
        send_codeword(d, compute_checks(d));
    endtask

    // Random codeword with a chosen class of damage
    task automatic build_random_item(output logic [DATA_W-1:0] d,
                                     output logic [CHECK_W-1:0] c);
        int  sel;
        int  hits;
        int  l;
        logic [DATA_W-1:0] err;

        sel = $urandom_range(0, 19);
        d   = DATA_W'($urandom);
        c   = compute_checks(d);
        err = '0;
        if (sel >= 2 && sel <= 6) begin
            // Singles in a random subset of layers
            hits = 0;
            for (int i = 0; i < LAYERS; i++) begin
                if ($urandom_range(0, 1) == 1 || (i == LAYERS - 1 && hits == 0)) begin
                    err ^= bit_at(cell_bit(i, $urandom_range(0, SIDE - 1),
                                           $urandom_range(0, SIDE - 1)));
                    hits++;
                end
            end
            d ^= err;
            if (sel == 6)
                c ^= CHECK_W'(1) << $urandom_range(0, CHECK_W - 1);
        end
        else if (sel >= 7 && sel <= 13) begin
            l = $urandom_range(0, LAYERS - 1);
            d ^= pair_mask(l, 1'($urandom_range(0, 1)));
            if (sel >= 12)
                flip_any(d, c);
        end
        else if (sel >= 14 && sel <= 17) begin
            hits = $urandom_range(1, 4);
            for (int i = 0; i < hits; i++)
                flip_any(d, c);
        end
        else if (sel >= 18) begin
            c = CHECK_W'($urandom);
        end
    endtask

    // Receiver: switch between stall patterns after a random hold
    always @(posedge clk) begin
        if (rx_hold == 0) begin
            rx_mode    <= $urandom_range(0, 3);
            rx_hold    <= $urandom_range(20, 200);
            rx_pattern <= 16'($urandom);
        end
        else begin
            rx_hold <= rx_hold - 1;
        end
        rx_phase <= rx_phase + 4'd1;
        case (rx_mode)
            0:       result_ch.ready <= 1'b1;
            1:       result_ch.ready <= rx_pattern[rx_phase];
            2:       result_ch.ready <= 1'($urandom_range(0, 1));
            default: result_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Stimulus and verdict
    initial begin
        logic [DATA_W-1:0]  d;
        logic [CHECK_W-1:0] c;

        rst_n              = 1'b0;
        code_ch.valid      = 1'b0;
        code_ch.data_word  = '0;
        code_ch.check_word = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        for (int n = 0; n < 1800; n++) begin
            build_random_item(d, c);
            send_codeword(d, c);
        end
        code_ch.valid <= 1'b0;

        // Drain, then let the pipeline settle
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ppd3_pkg.sv
hw/rtl/ppd3_if.sv
hw/rtl/ppd3_syndrome.sv
hw/rtl/ppd3_correct.sv
hw/rtl/product_parity_3d_decoder.sv
test/ppd3_decode_checker.sv
test/tb.sv
